@@ rtl/wpp_pkg.sv @@
// shared types, constants and helper functions for the windowed polyline projection
// no dependencies
package wpp_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOOP,
        ST_RDA,
        ST_RDB,
        ST_DIFF,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_TDEC,
        ST_DIV,
        ST_SC1,
        ST_SC2,
        ST_SC3,
        ST_OFS,
        ST_E1,
        ST_E2,
        ST_E3,
        ST_FIN,
        ST_CR1,
        ST_CR2,
        ST_CR3,
        ST_SQRT,
        ST_NORM,
        ST_ROT,
        ST_DONE
    } state_t;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic signed [31:0] SAT_POS = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_NEG = 32'sh8000_0001;
    localparam logic [3:0] CORDIC_LAST = 4'd14;
    localparam logic [15:0] HALF_TURN = 16'h8000;

    // arctangent table, binary angle with 65536 per turn
    function automatic logic [15:0] atan_entry(input logic [3:0] step);
        logic [15:0] v;
        begin
            case (step)
                4'd0:    v = 16'd8192;
                4'd1:    v = 16'd4836;
                4'd2:    v = 16'd2555;
                4'd3:    v = 16'd1297;
                4'd4:    v = 16'd651;
                4'd5:    v = 16'd326;
                4'd6:    v = 16'd163;
                4'd7:    v = 16'd81;
                4'd8:    v = 16'd41;
                4'd9:    v = 16'd20;
                4'd10:   v = 16'd10;
                4'd11:   v = 16'd5;
                4'd12:   v = 16'd3;
                4'd13:   v = 16'd1;
                4'd14:   v = 16'd1;
                default: v = 16'd0;
            endcase
            return v;
        end
    endfunction

    // a - b saturated to +-(2^31-1)
    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        begin
            d = {a[31], a} - {b[31], b};
            if (d > 33'sd2147483647)
                return SAT_POS;
            else if (d < -33'sd2147483647)
                return SAT_NEG;
            else
                return d[31:0];
        end
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        begin
            return a[31] ? 32'(-a) : 32'(a);
        end
    endfunction

endpackage

@@ rtl/wpp_ram.sv @@
// generic single-port synchronous ram with registered read
// no dependencies
module wpp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/windowed_polyline_projection_top.sv @@
// windowed point-to-polyline projection, top level
// depends on wpp_pkg and wpp_ram
// a load word writes its waypoint to its slot; a query runs up to one divide per segment over the S
// segments in the window (at most WINDOW_BACK+WINDOW_AHEAD), then the square root, the normalize
// steps and the 15-step cordic on the winner, all over one shared multiplier, before the result
// word; an empty window goes straight to the result word
// one query is in flight at a time; a finished result waits in the output register
// rst_n clears control state and path_length; the waypoint store is not cleared
module windowed_polyline_projection_top #(
    parameter int PATH_DEPTH   = 256,
    parameter int WINDOW_BACK  = 2,
    parameter int WINDOW_AHEAD = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,  // slot, wp_x, wp_z, rover_x, rover_z, hint
    input  logic [0:0]   s_tuser,  // mode
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,  // cross_track, heading, seg_index
    output logic [0:0]   m_tuser,  // found
    // path_length register
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [8:0]   cfg_data
);
    import wpp_pkg::*;

    localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int IW = (AW > 10) ? AW + 1 : 11;

    // input word fields
    logic              in_mode;
    logic [7:0]        in_slot;
    logic signed [31:0] in_wp_x, in_wp_z, in_rover_x, in_rover_z;
    logic [7:0]        in_hint;

    assign in_mode    = s_tuser[0];
    assign in_slot    = s_tdata[7:0];
    assign in_wp_x    = s_tdata[39:8];
    assign in_wp_z    = s_tdata[71:40];
    assign in_rover_x = s_tdata[103:72];
    assign in_rover_z = s_tdata[135:104];
    assign in_hint    = s_tdata[143:136];

    state_t state_reg, state_next;

    logic [8:0]          plen_reg;
    logic signed [31:0]  rx_reg, rz_reg;
    logic [7:0]          hint_reg;
    logic signed [IW-1:0] idx_reg, end_reg, idx_p1;
    logic signed [31:0]  x1_reg, z1_reg;
    logic signed [31:0]  dx_reg, dz_reg, ax_reg, az_reg;
    logic signed [31:0]  tdx_reg, tdz_reg, ox_reg, oz_reg;
    logic signed [63:0]  prod_reg, dot_reg, cprod_reg;
    logic [63:0]         len_reg, rem_reg, err_reg;
    logic [31:0]         q_reg;
    logic [5:0]          cnt_reg;
    logic                found_reg;
    logic [63:0]         best_err_reg;
    logic signed [31:0]  best_dx_reg, best_dz_reg, best_ox_reg, best_oz_reg;
    logic [7:0]          best_seg_reg;
    logic [63:0]         sq_v_reg, sq_res_reg, sq_bit_reg;
    logic                cross_neg_reg;
    logic signed [35:0]  cx_reg, cy_reg;
    logic [15:0]         ang_reg;

    logic                m_tvalid_reg;
    logic [55:0]         m_tdata_reg;
    logic                m_tuser_reg;

    // shared multiplier
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  mul_p;

    // ram port
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [63:0]         ram_wdata, ram_rdata;

    logic                in_fire, load_fire, query_fire;
    logic                out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign load_fire = in_fire && (in_mode == MODE_LOAD);
    assign query_fire = in_fire && (in_mode == MODE_QUERY);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign idx_p1    = idx_reg + IW'(1);

    // writes beyond the store are dropped
    assign ram_we    = load_fire && (32'(in_slot) < 32'(PATH_DEPTH));
    assign ram_wdata = {in_wp_z, in_wp_x};

    always_comb
    begin
        case (state_reg)
            ST_RDA:  ram_addr = idx_reg[AW-1:0];
            ST_RDB:  ram_addr = idx_p1[AW-1:0];
            default: ram_addr = AW'(in_slot);
        endcase
    end

    wpp_ram #(
        .WIDTH(64),
        .DEPTH(PATH_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // multiplier operand select, product registered every cycle
    always_comb
    begin
        case (state_reg)
            ST_M1:   begin mul_a = {dx_reg[31], dx_reg}; mul_b = {dx_reg[31], dx_reg}; end
            ST_M2:   begin mul_a = {dz_reg[31], dz_reg}; mul_b = {dz_reg[31], dz_reg}; end
            ST_M3:   begin mul_a = {ax_reg[31], ax_reg}; mul_b = {dx_reg[31], dx_reg}; end
            ST_M4:   begin mul_a = {az_reg[31], az_reg}; mul_b = {dz_reg[31], dz_reg}; end
            ST_SC1:  begin mul_a = {1'b0, abs32(dx_reg)}; mul_b = {1'b0, q_reg}; end
            ST_SC2:  begin mul_a = {1'b0, abs32(dz_reg)}; mul_b = {1'b0, q_reg}; end
            ST_E1:   begin mul_a = {ox_reg[31], ox_reg}; mul_b = {ox_reg[31], ox_reg}; end
            ST_E2:   begin mul_a = {oz_reg[31], oz_reg}; mul_b = {oz_reg[31], oz_reg}; end
            ST_CR1:
            begin
                mul_a = {best_dx_reg[31], best_dx_reg};
                mul_b = {best_oz_reg[31], best_oz_reg};
            end
            ST_CR2:
            begin
                mul_a = {best_dz_reg[31], best_dz_reg};
                mul_b = {best_ox_reg[31], best_ox_reg};
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // datapath helpers
    logic [63:0]         err_sum;
    logic [64:0]         rem_sh;
    logic [31:0]         round_p;
    logic [63:0]         sq_sum;
    logic signed [64:0]  cross_diff;
    logic                cx_small, cy_small;
    logic signed [IW-1:0] hint_ext, start_val, end_val, ahead_val;

    assign err_sum    = err_reg + 64'(prod_reg);
    assign rem_sh     = {rem_reg, 1'b0};
    assign round_p    = 32'((64'(prod_reg) + 64'h8000_0000) >> 32);
    assign sq_sum     = sq_res_reg + sq_bit_reg;
    assign cross_diff = {cprod_reg[63], cprod_reg} - {prod_reg[63], prod_reg};
    assign cx_small   = (cx_reg < 36'sh0_4000_0000) && (cx_reg > -36'sh0_4000_0000);
    assign cy_small   = (cy_reg < 36'sh0_4000_0000) && (cy_reg > -36'sh0_4000_0000);

    // window bounds: start floors at zero, end is exclusive
    assign hint_ext  = IW'(in_hint);
    assign ahead_val = hint_ext + IW'(WINDOW_AHEAD);
    assign start_val = (in_hint > 8'(WINDOW_BACK)) ? hint_ext - IW'(WINDOW_BACK) : '0;
    assign end_val   = (ahead_val >= $signed(IW'(plen_reg))) ? $signed(IW'(plen_reg)) - IW'(1)
                                                             : ahead_val;

    // result formatting
    logic [31:0] cross_out;

    always_comb
    begin
        if (!found_reg)
            cross_out = '0;
        else if (!cross_neg_reg)
            cross_out = (sq_res_reg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : sq_res_reg[31:0];
        else
            cross_out = (sq_res_reg >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-sq_res_reg[31:0]);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (query_fire) state_next = ST_LOOP;
            ST_LOOP: state_next = (idx_reg < end_reg) ? ST_RDA : ST_FIN;
            ST_RDA:  state_next = ST_RDB;
            ST_RDB:  state_next = ST_DIFF;
            ST_DIFF: state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_M4;
            ST_M4:   state_next = ST_M5;
            ST_M5:   state_next = ST_TDEC;
            ST_TDEC:
            begin
                if (len_reg == '0 || dot_reg <= 64'sd0 || 64'(dot_reg) >= len_reg)
                    state_next = ST_OFS;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:  if (cnt_reg == 6'd31) state_next = ST_SC1;
            ST_SC1:  state_next = ST_SC2;
            ST_SC2:  state_next = ST_SC3;
            ST_SC3:  state_next = ST_OFS;
            ST_OFS:  state_next = ST_E1;
            ST_E1:   state_next = ST_E2;
            ST_E2:   state_next = ST_E3;
            ST_E3:   state_next = ST_LOOP;
            ST_FIN:  state_next = found_reg ? ST_CR1 : ST_DONE;
            ST_CR1:  state_next = ST_CR2;
            ST_CR2:  state_next = ST_CR3;
            ST_CR3:  state_next = ST_SQRT;
            ST_SQRT: if (cnt_reg == 6'd31) state_next = ST_NORM;
            ST_NORM:
            begin
                if (cx_reg == '0 && cy_reg == '0)
                    state_next = ST_DONE;
                else if (!(cx_small && cy_small))
                    state_next = ST_ROT;
            end
            ST_ROT:  if (cnt_reg[3:0] == CORDIC_LAST) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (32'(cfg_data) > 32'(PATH_DEPTH))
                    plen_reg <= 9'(PATH_DEPTH);
                else
                    plen_reg <= cfg_data;
            end
            if (state_reg == ST_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (query_fire)
                found_reg <= 1'b0;
            else if (state_reg == ST_E3)
                found_reg <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p[63:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (query_fire)
                begin
                    rx_reg   <= in_rover_x;
                    rz_reg   <= in_rover_z;
                    hint_reg <= in_hint;
                    idx_reg  <= start_val;
                    end_reg  <= end_val;
                end
            end
            ST_DIFF:
            begin
                // start point arrived last cycle, end point now
                dx_reg <= sat_sub(ram_rdata[31:0], x1_reg);
                dz_reg <= sat_sub(ram_rdata[63:32], z1_reg);
                ax_reg <= sat_sub(rx_reg, x1_reg);
                az_reg <= sat_sub(rz_reg, z1_reg);
            end
            ST_RDB:
            begin
                x1_reg <= ram_rdata[31:0];
                z1_reg <= ram_rdata[63:32];
            end
            ST_M2: len_reg <= 64'(prod_reg);
            ST_M3: len_reg <= len_reg + 64'(prod_reg);
            ST_M4: dot_reg <= prod_reg;
            ST_M5: dot_reg <= dot_reg + prod_reg;
            ST_TDEC:
            begin
                rem_reg <= 64'(dot_reg);
                q_reg   <= '0;
                cnt_reg <= '0;
                // zero-length segment or point behind start: t = 0
                if (len_reg == '0 || dot_reg <= 64'sd0)
                begin
                    tdx_reg <= '0;
                    tdz_reg <= '0;
                end
                else
                begin
                    tdx_reg <= dx_reg;
                    tdz_reg <= dz_reg;
                end
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                if (rem_sh >= {1'b0, len_reg})
                begin
                    rem_reg <= 64'(rem_sh - {1'b0, len_reg});
                    q_reg   <= {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[63:0];
                    q_reg   <= {q_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            ST_SC2: tdx_reg <= dx_reg[31] ? $signed(-round_p) : $signed(round_p);
            ST_SC3: tdz_reg <= dz_reg[31] ? $signed(-round_p) : $signed(round_p);
            ST_OFS:
            begin
                ox_reg <= sat_sub(ax_reg, tdx_reg);
                oz_reg <= sat_sub(az_reg, tdz_reg);
            end
            ST_E2: err_reg <= 64'(prod_reg);
            ST_E3:
            begin
                // first strictly smaller distance wins
                if (!found_reg || err_sum < best_err_reg)
                begin
                    best_err_reg <= err_sum;
                    best_dx_reg  <= dx_reg;
                    best_dz_reg  <= dz_reg;
                    best_ox_reg  <= ox_reg;
                    best_oz_reg  <= oz_reg;
                    best_seg_reg <= idx_reg[7:0];
                end
                idx_reg <= idx_p1;
            end
            ST_FIN:
            begin
                ang_reg <= '0;
            end
            ST_CR2: cprod_reg <= prod_reg;
            ST_CR3:
            begin
                cross_neg_reg <= cross_diff[64];
                sq_v_reg      <= best_err_reg;
                sq_res_reg    <= '0;
                sq_bit_reg    <= 64'h4000_0000_0000_0000;
                cnt_reg       <= '0;
                cx_reg        <= 36'(best_dx_reg);
                cy_reg        <= 36'(best_dz_reg);
            end
            ST_SQRT:
            begin
                if (sq_v_reg >= sq_sum)
                begin
                    sq_v_reg   <= sq_v_reg - sq_sum;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                cnt_reg    <= cnt_reg + 6'd1;
            end
            ST_NORM:
            begin
                // double until a component reaches 2^30, then fold into right half plane
                cnt_reg <= '0;
                if (cx_small && cy_small)
                begin
                    cx_reg <= cx_reg <<< 1;
                    cy_reg <= cy_reg <<< 1;
                end
                else if (cx_reg < 36'sd0)
                begin
                    cx_reg  <= -cx_reg;
                    cy_reg  <= -cy_reg;
                    ang_reg <= HALF_TURN;
                end
            end
            ST_ROT:
            begin
                // a step with y at zero leaves everything unchanged
                if (cy_reg > 36'sd0)
                begin
                    cx_reg  <= cx_reg + (cy_reg >>> cnt_reg[3:0]);
                    cy_reg  <= cy_reg - (cx_reg >>> cnt_reg[3:0]);
                    ang_reg <= ang_reg + atan_entry(cnt_reg[3:0]);
                end
                else if (cy_reg < 36'sd0)
                begin
                    cx_reg  <= cx_reg - (cy_reg >>> cnt_reg[3:0]);
                    cy_reg  <= cy_reg + (cx_reg >>> cnt_reg[3:0]);
                    ang_reg <= ang_reg - atan_entry(cnt_reg[3:0]);
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_reg[31:0]  <= cross_out;
                    m_tdata_reg[47:32] <= found_reg ? ang_reg : 16'd0;
                    m_tdata_reg[55:48] <= found_reg ? best_seg_reg : hint_reg;
                    m_tuser_reg        <= found_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
